### rtl/core/kbl_pkg.sv
// ----------------------------------------------------------------------------
// kbl_pkg: shared definitions for the k-th successor block
// Field widths, operation and register codes, payload types and the
// command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package kbl_pkg;

   // Default sizing of the jump table.
   localparam int MAX_VERTICES = 1024;
   localparam int MAX_LEVELS   = 32;

   // Widths of the request and response fields.
   localparam int OP_WIDTH     = 1;
   localparam int VERTEX_WIDTH = 10;
   localparam int STEPS_WIDTH  = 32;
   localparam int LEVEL_WIDTH  = 5;
   localparam int COUNT_WIDTH  = 11;

   // Configuration port.
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH  = 11;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_VERTEX_COUNT = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TOP_LEVEL    = 1'd1;

   // Operation codes.
   localparam logic [OP_WIDTH-1:0] OP_WRITE = 1'd0;
   localparam logic [OP_WIDTH-1:0] OP_QUERY = 1'd1;

   // Status codes.
   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_RANGE = 1'b1;

   // One request as it arrives on the input channel.
   typedef struct packed {
      logic [OP_WIDTH-1:0]     op;
      logic [VERTEX_WIDTH-1:0] vertex;
      logic [VERTEX_WIDTH-1:0] successor;
      logic [STEPS_WIDTH-1:0]  steps;
   } req_type;

   // One response as it leaves on the result channel.
   typedef struct packed {
      logic                    status;
      logic [VERTEX_WIDTH-1:0] end_vertex;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;
      logic rb_start;
      logic rb_rd_src;
      logic rb_rd_mid;
      logic rb_write;
      logic clear_stale;
      logic walk_step;
      logic walk_finish;
      logic emit;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic req_is_query;
      logic req_error;
      logic stale;
      logic top_zero;
      logic rb_last;
      logic walk_last;
      logic out_free;
   } stat_type;

endpackage

### rtl/core/kbl_stream_if.sv
// ----------------------------------------------------------------------------
// kbl_stream_if: valid/ready channel
// Carries one payload per handshake; the source drives valid and payload,
// the sink drives ready.
// ----------------------------------------------------------------------------
interface kbl_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

### rtl/core/kbl_ram.sv
// ----------------------------------------------------------------------------
// kbl_ram: generic simple dual-port RAM
// One write port and one read port, with a registered read.
// ----------------------------------------------------------------------------
module kbl_ram #(
   parameter int   WIDTH = kbl_pkg::VERTEX_WIDTH,
   parameter int   DEPTH = kbl_pkg::MAX_VERTICES,
   localparam int  AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read; the read data holds between reads.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/kbl_ctrl.sv
// ----------------------------------------------------------------------------
// kbl_ctrl: sequencer for the k-th successor block
// Accepts one request at a time, runs the level rebuild when the table is
// stale, steps the query walk and hands the response to the output stage.
// ----------------------------------------------------------------------------
module kbl_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  kbl_pkg::stat_type  stat,
   output kbl_pkg::cmd_type   cmd
);

   typedef enum logic [6:0] {
      S_IDLE     = 7'b0000001,
      S_RB_FIRST = 7'b0000010,
      S_RB_MID   = 7'b0000100,
      S_RB_WRITE = 7'b0001000,
      S_WALK     = 7'b0010000,
      S_DONE     = 7'b0100000,
      S_RESP     = 7'b1000000
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_ready = (state_ff == S_IDLE);

   // Next state and datapath commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (!stat.req_is_query || stat.req_error) begin
                  state_in = S_RESP;
               end else if (stat.stale && !stat.top_zero) begin
                  cmd.rb_start = 1'b1;
                  state_in     = S_RB_FIRST;
               end else begin
                  cmd.clear_stale = stat.stale;
                  state_in        = S_WALK;
               end
            end
         end
         S_RB_FIRST: begin
            cmd.rb_rd_src = 1'b1;
            state_in      = S_RB_MID;
         end
         S_RB_MID: begin
            cmd.rb_rd_mid = 1'b1;
            state_in      = S_RB_WRITE;
         end
         S_RB_WRITE: begin
            cmd.rb_write = 1'b1;
            if (stat.rb_last) begin
               cmd.clear_stale = 1'b1;
               state_in        = S_WALK;
            end else begin
               state_in = S_RB_MID;
            end
         end
         S_WALK: begin
            cmd.walk_step = 1'b1;
            if (stat.walk_last) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            cmd.walk_finish = 1'b1;
            state_in        = S_RESP;
         end
         S_RESP: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### rtl/core/kbl_datapath.sv
// ----------------------------------------------------------------------------
// kbl_datapath: jump table, counters and result stage
// Holds the configuration, the stale flag, the jump table RAM, the rebuild
// and walk counters and the response output register.
// ----------------------------------------------------------------------------
module kbl_datapath #(
   parameter int MAX_VERTICES = kbl_pkg::MAX_VERTICES,
   parameter int MAX_LEVELS   = kbl_pkg::MAX_LEVELS
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  kbl_pkg::req_type                       req_payload,
   output kbl_pkg::rsp_type                       rsp_payload,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   input  logic                                   csr_wr_en,
   input  logic [kbl_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [kbl_pkg::CSR_DATA_WIDTH-1:0]     csr_wr_data,
   input  kbl_pkg::cmd_type                       cmd,
   output kbl_pkg::stat_type                      stat
);

   localparam int VW       = $clog2(MAX_VERTICES);
   localparam int LW       = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
   localparam int AW       = LW + VW;
   localparam int DEPTH    = 2 ** AW;
   localparam int VXW      = kbl_pkg::VERTEX_WIDTH;
   localparam int LVW      = kbl_pkg::LEVEL_WIDTH;
   localparam int CW       = kbl_pkg::COUNT_WIDTH;
   localparam int LAST_LV  = (MAX_LEVELS - 1 < 31) ? MAX_LEVELS - 1 : 31;
   localparam int VC_RESET = (MAX_VERTICES < 1024) ? MAX_VERTICES : 1024;
   localparam int VC_CLAMP = (MAX_VERTICES < 2047) ? MAX_VERTICES : 2047;
   localparam logic [VW-1:0] LAST_VERTEX = VW'(MAX_VERTICES - 1);

   // Map a stored successor onto a table row; rows past the table read row 0.
   function automatic logic [VW-1:0] safe_vertex(input logic [VXW-1:0] v);
      return (32'(v) < 32'(MAX_VERTICES)) ? VW'(v) : '0;
   endfunction

   logic [CW-1:0]          vcount_ff;
   logic [LVW-1:0]         top_ff;
   logic                   stale_ff;
   logic [kbl_pkg::STEPS_WIDTH-1:0] steps_ff;
   logic [VW-1:0]          cur_ff, cur_in;
   logic [LVW-1:0]         walk_lv_ff;
   logic                   pend_ff;
   logic [LVW-1:0]         rb_lv_ff, rb_lv_in;
   logic [VW-1:0]          rb_v_ff, rb_v_in;
   logic                   res_status_ff;
   logic [VXW-1:0]         res_vertex_ff;
   logic                   rsp_valid_ff;
   kbl_pkg::rsp_type       rsp_ff;

   logic                   req_error;
   logic                   write_ok;
   logic                   step_bit;
   logic                   rb_last_v;
   logic                   out_free;
   logic [CW-1:0]          vc_sat;
   logic [LVW-1:0]         top_sat;

   logic                   wr_en;
   logic [LVW-1:0]         wr_lvl;
   logic [VW-1:0]          wr_vtx;
   logic [VXW-1:0]         wr_data;
   logic                   rd_en;
   logic [LVW-1:0]         rd_lvl;
   logic [VW-1:0]          rd_vtx;
   logic [VXW-1:0]         rd_data;

   // Range check of the incoming request against the vertex count.
   always_comb begin
      req_error = (CW'(req_payload.vertex) >= vcount_ff);
      if (req_payload.op == kbl_pkg::OP_WRITE) begin
         req_error = req_error || (CW'(req_payload.successor) >= vcount_ff);
      end
   end

   assign write_ok  = cmd.accept && (req_payload.op == kbl_pkg::OP_WRITE) && !req_error;
   assign step_bit  = steps_ff[walk_lv_ff];
   assign rb_last_v = (rb_v_ff == LAST_VERTEX);
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // Walk position: a pending read replaces the current vertex.
   always_comb begin
      cur_in = pend_ff ? safe_vertex(rd_data) : cur_ff;
   end

   // Rebuild counters advance over all vertices, then to the next level.
   always_comb begin
      if (rb_last_v) begin
         rb_v_in  = '0;
         rb_lv_in = LVW'(rb_lv_ff + 1'b1);
      end else begin
         rb_v_in  = VW'(rb_v_ff + 1'b1);
         rb_lv_in = rb_lv_ff;
      end
   end

   // Saturated configuration values.
   always_comb begin
      vc_sat = csr_wr_data[CW-1:0];
      if (vc_sat == '0) begin
         vc_sat = CW'(1);
      end else if (32'(vc_sat) > VC_CLAMP) begin
         vc_sat = CW'(VC_CLAMP);
      end
      top_sat = csr_wr_data[LVW-1:0];
      if (32'(top_sat) > LAST_LV) begin
         top_sat = LVW'(LAST_LV);
      end
   end

   // Jump table write port: level 0 entries from requests, rebuilt levels.
   always_comb begin
      wr_en   = 1'b0;
      wr_lvl  = '0;
      wr_vtx  = '0;
      wr_data = '0;
      if (write_ok) begin
         wr_en   = 1'b1;
         wr_vtx  = VW'(req_payload.vertex);
         wr_data = req_payload.successor;
      end else if (cmd.rb_write) begin
         wr_en   = 1'b1;
         wr_lvl  = rb_lv_ff;
         wr_vtx  = rb_v_ff;
         wr_data = rd_data;
      end
   end

   // Jump table read port, shared by the rebuild and the walk.
   always_comb begin
      rd_en  = 1'b0;
      rd_lvl = '0;
      rd_vtx = '0;
      if (cmd.rb_rd_src) begin
         rd_en  = 1'b1;
         rd_lvl = LVW'(rb_lv_ff - 1'b1);
         rd_vtx = rb_v_ff;
      end else if (cmd.rb_rd_mid) begin
         rd_en  = 1'b1;
         rd_lvl = LVW'(rb_lv_ff - 1'b1);
         rd_vtx = safe_vertex(rd_data);
      end else if (cmd.rb_write) begin
         rd_en  = 1'b1;
         rd_lvl = LVW'(rb_lv_in - 1'b1);
         rd_vtx = rb_v_in;
      end else if (cmd.walk_step && step_bit) begin
         rd_en  = 1'b1;
         rd_lvl = walk_lv_ff;
         rd_vtx = cur_in;
      end
   end

   kbl_ram #(
      .WIDTH (VXW),
      .DEPTH (DEPTH)
   ) u_jump_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr ({LW'(wr_lvl), wr_vtx}),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr ({LW'(rd_lvl), rd_vtx}),
      .rd_data (rd_data)
   );

   // Configuration registers and the stale flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff <= CW'(VC_RESET);
         top_ff    <= LVW'(LAST_LV);
         stale_ff  <= 1'b1;
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index)
               kbl_pkg::CSR_VERTEX_COUNT: vcount_ff <= vc_sat;
               kbl_pkg::CSR_TOP_LEVEL:    top_ff    <= top_sat;
               default: ;
            endcase
            stale_ff <= 1'b1;
         end else if (write_ok) begin
            stale_ff <= 1'b1;
         end else if (cmd.clear_stale) begin
            stale_ff <= 1'b0;
         end
      end
   end

   // Request capture, walk and rebuild registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
      end else begin
         if (cmd.accept) begin
            pend_ff <= 1'b0;
         end else if (cmd.walk_step) begin
            pend_ff <= step_bit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         steps_ff      <= req_payload.steps;
         cur_ff        <= VW'(req_payload.vertex);
         walk_lv_ff    <= top_ff;
         res_status_ff <= req_error ? kbl_pkg::STATUS_RANGE : kbl_pkg::STATUS_OK;
         res_vertex_ff <= '0;
      end else if (cmd.walk_step) begin
         cur_ff     <= cur_in;
         walk_lv_ff <= LVW'(walk_lv_ff - 1'b1);
      end else if (cmd.walk_finish) begin
         res_status_ff <= kbl_pkg::STATUS_OK;
         res_vertex_ff <= VXW'(cur_in);
      end
      if (cmd.rb_start) begin
         rb_lv_ff <= LVW'(1);
         rb_v_ff  <= '0;
      end else if (cmd.rb_write) begin
         rb_lv_ff <= rb_lv_in;
         rb_v_ff  <= rb_v_in;
      end
   end

   // Response output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_ff.status     <= res_status_ff;
         rsp_ff.end_vertex <= res_vertex_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // Status toward the controller.
   assign stat.req_is_query = (req_payload.op == kbl_pkg::OP_QUERY);
   assign stat.req_error    = req_error;
   assign stat.stale        = stale_ff;
   assign stat.top_zero     = (top_ff == '0);
   assign stat.rb_last      = rb_last_v && (rb_lv_ff == top_ff);
   assign stat.walk_last    = (walk_lv_ff == '0);
   assign stat.out_free     = out_free;

endmodule

### rtl/core/kth_successor_binary_lifting.sv
// ----------------------------------------------------------------------------
// kth_successor_binary_lifting: k-th successor by binary lifting
// Top level: joins the controller and the datapath to the channels and
// the configuration port.
// ----------------------------------------------------------------------------
// The block takes one request at a time. A write request passes from
// acceptance through the response state into the output register once
// that register is free. A query over current levels walks every level
// from top_level down to 0; each set step bit costs one dependent read of
// the jump table RAM, and the read data feeds the next address directly.
// When the levels are stale (after any successful write or register write)
// the first in-range query first rebuilds levels 1 through top_level; for a
// nonzero top_level each jump table entry takes two dependent reads on the
// single read port of the jump table RAM. A finished response waits in the
// output register while the next request is accepted.
module kth_successor_binary_lifting #(
   parameter int MAX_VERTICES = kbl_pkg::MAX_VERTICES,
   parameter int MAX_LEVELS   = kbl_pkg::MAX_LEVELS
) (
   input  logic                                clock,
   input  logic                                reset,
   kbl_stream_if.sink                          req_chan,
   kbl_stream_if.source                        rsp_chan,
   input  logic                                csr_wr_en,
   input  logic [kbl_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [kbl_pkg::CSR_DATA_WIDTH-1:0]  csr_wr_data
);

   kbl_pkg::cmd_type  cmd;
   kbl_pkg::stat_type stat;
   kbl_pkg::req_type  req_payload;
   kbl_pkg::rsp_type  rsp_payload;
   logic              req_ready;
   logic              rsp_valid;

   // Channel connections.
   assign req_payload      = req_chan.payload;
   assign req_chan.ready   = req_ready;
   assign rsp_chan.valid   = rsp_valid;
   assign rsp_chan.payload = rsp_payload;

   kbl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   kbl_datapath #(
      .MAX_VERTICES (MAX_VERTICES),
      .MAX_LEVELS   (MAX_LEVELS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .rsp_payload (rsp_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_chan.ready),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .stat        (stat)
   );

endmodule

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for kth_successor_binary_lifting
// Loads a full successor graph, runs directed cases for the range checks,
// the ignored step bits and the register limits, then random bursts of
// successor writes and k-th successor queries under changing settings.
// Every response is compared with a binary lifting predictor kept here.
// ----------------------------------------------------------------------------
module testbench;

   localparam int VXW      = kbl_pkg::VERTEX_WIDTH;
   localparam int CNW      = kbl_pkg::COUNT_WIDTH;
   localparam int LVW      = kbl_pkg::LEVEL_WIDTH;
   localparam int CDW      = kbl_pkg::CSR_DATA_WIDTH;
   localparam int OWED_AW  = 4;
   localparam int OWED_DEPTH = 1 << OWED_AW;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [kbl_pkg::CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CDW-1:0] csr_wr_data;

   kbl_stream_if #(.payload_type(kbl_pkg::req_type)) req_chan ();
   kbl_stream_if #(.payload_type(kbl_pkg::rsp_type)) rsp_chan ();

   kth_successor_binary_lifting dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   // Predictor state: jump levels, stale flag and register copies.
   logic [VXW-1:0] hop_table [kbl_pkg::MAX_LEVELS][kbl_pkg::MAX_VERTICES];
   logic levels_stale;
   logic [CNW-1:0] vertex_count;
   logic [LVW-1:0] top_level;

   // Responses still owed by the block, oldest first, in a small ring.
   kbl_pkg::rsp_type owed_ring [OWED_DEPTH];
   int owed_pushed = 0;
   int owed_popped = 0;

   int send_idle_pct;
   int rsp_idle_pct;
   bit request_up;
   int fail_count;
   int check_fails = 0;
   int n_writes;
   int n_queries;
   int n_range;
   int n_rebuilds;
   int n_settings;
   int max_top;

   // Clock with a period of 4.
   initial clock = 1'b0;
   always #2 clock = ~clock;

   // Rebuild levels 1 through top_level over every vertex.
   function automatic void refresh_levels();
      int lv;
      int v;
      for (lv = 1; lv <= top_level; lv++) begin
         for (v = 0; v < kbl_pkg::MAX_VERTICES; v++) begin
            hop_table[lv][v] = hop_table[lv-1][hop_table[lv-1][v]];
         end
      end
      levels_stale = 1'b0;
      n_rebuilds++;
   endfunction

   // Update the register copies the way the block saturates them.
   function automatic void note_register(input logic [kbl_pkg::CSR_INDEX_WIDTH-1:0] idx,
                                         input logic [CDW-1:0] data);
      if (idx == kbl_pkg::CSR_VERTEX_COUNT) begin
         if (data == 0) begin
            vertex_count = CNW'(1);
         end else if (data > kbl_pkg::MAX_VERTICES) begin
            vertex_count = CNW'(kbl_pkg::MAX_VERTICES);
         end else begin
            vertex_count = data;
         end
      end else begin
         top_level = data[LVW-1:0];
         if (top_level > kbl_pkg::MAX_LEVELS - 1) begin
            top_level = LVW'(kbl_pkg::MAX_LEVELS - 1);
         end
         if (top_level > max_top) begin
            max_top = top_level;
         end
      end
      levels_stale = 1'b1;
   endfunction

   // Work out the response to one accepted request and update the state.
   function automatic kbl_pkg::rsp_type predict_answer(input kbl_pkg::req_type r);
      kbl_pkg::rsp_type a;
      logic [VXW-1:0] here;
      int lv;
      a.status = kbl_pkg::STATUS_OK;
      a.end_vertex = '0;
      if (r.op == kbl_pkg::OP_WRITE) begin
         n_writes++;
         if (r.vertex >= vertex_count || r.successor >= vertex_count) begin
            a.status = kbl_pkg::STATUS_RANGE;
            n_range++;
         end else begin
            hop_table[0][r.vertex] = r.successor;
            levels_stale = 1'b1;
         end
      end else begin
         n_queries++;
         if (r.vertex >= vertex_count) begin
            a.status = kbl_pkg::STATUS_RANGE;
            n_range++;
         end else begin
            if (levels_stale) begin
               refresh_levels();
            end
            // Follow one level per set step bit, highest level first.
            here = r.vertex;
            for (lv = kbl_pkg::MAX_LEVELS - 1; lv >= 0; lv--) begin
               if (lv <= top_level && r.steps[lv]) begin
                  here = hop_table[lv][here];
               end
            end
            a.end_vertex = here;
         end
      end
      return a;
   endfunction

   // Build a random request within the current vertex count, or outside it.
   function automatic kbl_pkg::req_type random_request(
         input logic [kbl_pkg::OP_WIDTH-1:0] op, input bit out_of_range);
      kbl_pkg::req_type r;
      r.op = op;
      r.steps = $urandom();
      r.vertex = VXW'($urandom_range(0, vertex_count - 1));
      r.successor = VXW'($urandom_range(0, vertex_count - 1));
      if (out_of_range && vertex_count < kbl_pkg::MAX_VERTICES) begin
         case ((op == kbl_pkg::OP_QUERY) ? 0 : $urandom_range(2))
            0: begin
               r.vertex = VXW'($urandom_range(vertex_count, kbl_pkg::MAX_VERTICES - 1));
            end
            1: begin
               r.successor = VXW'($urandom_range(vertex_count, kbl_pkg::MAX_VERTICES - 1));
            end
            default: begin
               r.vertex = VXW'($urandom_range(vertex_count, kbl_pkg::MAX_VERTICES - 1));
               r.successor = VXW'($urandom_range(vertex_count, kbl_pkg::MAX_VERTICES - 1));
            end
         endcase
      end
      return r;
   endfunction

   // Send one request; valid stays high after acceptance so that a
   // following request can go out on the very next cycle.
   task automatic send_request(input kbl_pkg::req_type r);
      kbl_pkg::rsp_type answer;
      while ($urandom_range(99) < send_idle_pct) begin
         if (request_up) begin
            req_chan.valid <= 1'b0;
            request_up = 1'b0;
         end
         @(posedge clock);
      end
      req_chan.payload <= r;
      if (!request_up) begin
         req_chan.valid <= 1'b1;
         request_up = 1'b1;
      end
      do @(posedge clock); while (!req_chan.ready);
      answer = predict_answer(r);
      if (owed_pushed - owed_popped >= OWED_DEPTH) begin
         $display("%0t: too many responses owed, expected at most %0d, actual %0d",
                  $time, OWED_DEPTH - 1, owed_pushed - owed_popped);
         fail_count++;
      end
      owed_ring[OWED_AW'(owed_pushed)] = answer;
      owed_pushed++;
   endtask

   task automatic send_fields(input logic [kbl_pkg::OP_WIDTH-1:0] op,
                              input logic [VXW-1:0] vertex,
                              input logic [VXW-1:0] successor,
                              input logic [kbl_pkg::STEPS_WIDTH-1:0] steps);
      kbl_pkg::req_type r;
      r.op = op;
      r.vertex = vertex;
      r.successor = successor;
      r.steps = steps;
      send_request(r);
   endtask

   // Hold off new requests until every owed response has come back.
   task automatic wait_drain();
      if (request_up) begin
         req_chan.valid <= 1'b0;
         request_up = 1'b0;
      end
      while (owed_pushed != owed_popped) @(posedge clock);
   endtask

   // Write both registers once the block is idle.
   task automatic apply_settings(input logic [CDW-1:0] count_data,
                                 input logic [CDW-1:0] top_data);
      wait_drain();
      csr_wr_en <= 1'b1;
      csr_index <= kbl_pkg::CSR_VERTEX_COUNT;
      csr_wr_data <= count_data;
      @(posedge clock);
      note_register(kbl_pkg::CSR_VERTEX_COUNT, count_data);
      csr_index <= kbl_pkg::CSR_TOP_LEVEL;
      csr_wr_data <= top_data;
      @(posedge clock);
      note_register(kbl_pkg::CSR_TOP_LEVEL, top_data);
      csr_wr_en <= 1'b0;
      n_settings++;
   endtask

   // Give every vertex a successor so that no walk reads an unwritten entry.
   task automatic test_table_load();
      int v;
      for (v = 0; v < kbl_pkg::MAX_VERTICES; v++) begin
         send_fields(kbl_pkg::OP_WRITE, VXW'(v),
                     VXW'($urandom_range(0, kbl_pkg::MAX_VERTICES - 1)), $urandom());
      end
   endtask

   // Queries at the reset settings: all 32 levels and the extreme step counts.
   task automatic test_reset_levels();
      send_fields(kbl_pkg::OP_QUERY, VXW'(kbl_pkg::MAX_VERTICES - 1), '0, 32'hFFFF_FFFF);
      send_fields(kbl_pkg::OP_QUERY, 10'd0, VXW'(kbl_pkg::MAX_VERTICES - 1), 32'h0000_0000);
      send_fields(kbl_pkg::OP_QUERY, 10'd512, '1, 32'h8000_0000);
   endtask

   // A four-vertex ring: step bits above the top level, range errors.
   task automatic test_small_ring();
      apply_settings(11'd4, 11'd2);
      send_fields(kbl_pkg::OP_WRITE, 10'd0, 10'd1, '0);
      send_fields(kbl_pkg::OP_WRITE, 10'd1, 10'd2, '1);
      send_fields(kbl_pkg::OP_WRITE, 10'd2, 10'd3, '0);
      send_fields(kbl_pkg::OP_WRITE, 10'd3, 10'd0, '0);
      send_fields(kbl_pkg::OP_QUERY, 10'd0, '0, 32'd5);
      send_fields(kbl_pkg::OP_QUERY, 10'd2, '0, 32'hFFFF_FFFF);
      send_fields(kbl_pkg::OP_QUERY, 10'd1, '1, 32'hFFFF_FFF8);
      // Out-of-range write, on the vertex and on the successor.
      send_fields(kbl_pkg::OP_WRITE, 10'd4, 10'd0, '0);
      send_fields(kbl_pkg::OP_WRITE, 10'd3, 10'd4, '0);
      send_fields(kbl_pkg::OP_WRITE, VXW'(kbl_pkg::MAX_VERTICES - 1),
                  VXW'(kbl_pkg::MAX_VERTICES - 1), '0);
      // Out-of-range queries do not rebuild the levels.
      send_fields(kbl_pkg::OP_QUERY, 10'd4, '0, 32'd1);
      send_fields(kbl_pkg::OP_QUERY, VXW'(kbl_pkg::MAX_VERTICES - 1), '0, 32'hFFFF_FFFF);
      send_fields(kbl_pkg::OP_WRITE, 10'd3, 10'd3, '0);
      send_fields(kbl_pkg::OP_QUERY, 10'd0, '0, 32'd7);
   endtask

   // Count of zero saturates to one; top level data has junk in upper bits.
   task automatic test_single_vertex();
      apply_settings(11'd0, {6'b111111, 5'd0});
      send_fields(kbl_pkg::OP_WRITE, 10'd0, 10'd0, '0);
      send_fields(kbl_pkg::OP_QUERY, 10'd0, '0, 32'hFFFF_FFFF);
      send_fields(kbl_pkg::OP_QUERY, 10'd1, '0, 32'd0);
      send_fields(kbl_pkg::OP_WRITE, 10'd0, 10'd1, '0);
   endtask

   // Count above the maximum saturates to all vertices.
   task automatic test_count_saturation();
      apply_settings(11'd2047, {6'b101010, 5'd1});
      send_fields(kbl_pkg::OP_WRITE, VXW'(kbl_pkg::MAX_VERTICES - 1), 10'd0, '0);
      send_fields(kbl_pkg::OP_QUERY, VXW'(kbl_pkg::MAX_VERTICES - 1), '0, 32'd3);
      send_fields(kbl_pkg::OP_QUERY, 10'd0, '0, 32'hFFFF_FFFE);
   endtask

   // Random phases: new settings, then bursts of writes followed by queries.
   task automatic test_random_traffic(input int send_pct, input int rsp_pct,
                                      input int item_goal);
      int sent;
      int b;
      int nw;
      int nq;
      logic [CDW-1:0] count_data;
      logic [CDW-1:0] top_data;
      send_idle_pct = send_pct;
      rsp_idle_pct = rsp_pct;
      sent = 0;
      while (sent < item_goal) begin
         case ($urandom_range(9))
            0: count_data = '0;
            1: count_data = CDW'($urandom_range(kbl_pkg::MAX_VERTICES, 2047));
            2: count_data = CDW'($urandom_range(65, kbl_pkg::MAX_VERTICES - 1));
            default: count_data = CDW'($urandom_range(1, 64));
         endcase
         // Deep levels make the rebuild slow, so they stay rare.
         top_data = CDW'(($urandom_range(0, 63) << LVW) |
                         (($urandom_range(15) == 0) ? $urandom_range(5, 6)
                                                    : $urandom_range(0, 4)));
         apply_settings(count_data, top_data);
         for (b = 0; b < 3; b++) begin
            nw = $urandom_range(0, 6);
            nq = $urandom_range(1, 20);
            repeat (nw) begin
               send_request(random_request(kbl_pkg::OP_WRITE, $urandom_range(9) == 0));
            end
            repeat (nq) begin
               send_request(random_request(kbl_pkg::OP_QUERY, $urandom_range(9) == 0));
            end
            sent += nw + nq;
            if (b < 2 && $urandom_range(3) == 0) begin
               wait_drain();
            end
         end
      end
   endtask

   // Response ready toggles at random according to the current idle rate.
   always @(posedge clock) begin
      rsp_chan.ready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   // Compare each response with the oldest owed answer.
   always @(posedge clock) begin : check_answers
      kbl_pkg::rsp_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (owed_popped == owed_pushed) begin
            $display("%0t: response with none owed, status %0d end_vertex %0d",
                     $time, rsp_chan.payload.status, rsp_chan.payload.end_vertex);
            check_fails++;
         end else begin
            want = owed_ring[OWED_AW'(owed_popped)];
            owed_popped++;
            if (rsp_chan.payload.status !== want.status) begin
               $display("%0t: status mismatch, expected %0d, actual %0d",
                        $time, want.status, rsp_chan.payload.status);
               check_fails++;
            end
            if (rsp_chan.payload.end_vertex !== want.end_vertex) begin
               $display("%0t: end_vertex mismatch, expected %0d, actual %0d",
                        $time, want.end_vertex, rsp_chan.payload.end_vertex);
               check_fails++;
            end
         end
      end
   end

   // Run the tests in turn.
   initial begin
      int lv;
      int v;
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.payload = '0;
      csr_wr_en = 1'b0;
      csr_index = kbl_pkg::CSR_VERTEX_COUNT;
      csr_wr_data = '0;
      request_up = 1'b0;
      send_idle_pct = 10;
      rsp_idle_pct = 85;
      fail_count = 0;
      n_writes = 0;
      n_queries = 0;
      n_range = 0;
      n_rebuilds = 0;
      n_settings = 0;
      for (lv = 0; lv < kbl_pkg::MAX_LEVELS; lv++) begin
         for (v = 0; v < kbl_pkg::MAX_VERTICES; v++) begin
            hop_table[lv][v] = '0;
         end
      end
      levels_stale = 1'b1;
      vertex_count = CNW'(kbl_pkg::MAX_VERTICES);
      top_level = LVW'(kbl_pkg::MAX_LEVELS - 1);
      max_top = top_level;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_table_load();
      test_reset_levels();
      test_small_ring();
      test_single_vertex();
      test_count_saturation();
      test_random_traffic(10, 85, 340);
      test_random_traffic(85, 10, 340);
      test_random_traffic(0, 0, 340);

      wait_drain();
      repeat (64) @(posedge clock);
      if (owed_pushed != owed_popped) begin
         $display("%0t: responses never arrived, expected 0 owed, actual %0d",
                  $time, owed_pushed - owed_popped);
         fail_count++;
      end
      $display("Covered %0d writes and %0d queries, %0d of them out of range.",
               n_writes, n_queries, n_range);
      $display("Used %0d register settings, %0d level rebuilds, top level up to %0d.",
               n_settings, n_rebuilds, max_top);
      if (fail_count == 0 && check_fails == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

   // Hard stop in case the block hangs.
   initial begin
      #64000000;
      $display("testbench failed");
      $finish;
   end

endmodule
